>>> sv/lblt_pkg.sv
package lblt_pkg;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_RUN   = 2'd1,
    ST_DISP  = 2'd2
  } run_state_t;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_BREAK_WINDOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN         = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_LAP          = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RESTORE_DEBOUNCE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN_RESTORED     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LOST_TIMEOUT     = 3'd5;

  localparam logic [31:0] BREAK_WINDOW_RST     = 32'd4000;
  localparam logic [31:0] COOLDOWN_RST         = 32'd3000;
  localparam logic [31:0] MIN_LAP_RST          = 32'd1000000;
  localparam logic [31:0] RESTORE_DEBOUNCE_RST = 32'd200000;
  localparam logic [31:0] MIN_RESTORED_RST     = 32'd2000000;
  localparam logic [31:0] LOST_TIMEOUT_RST     = 32'd10000000;

endpackage

>>> sv/light_beam_lap_timer.sv
// Light beam lap timer, evaluated once per poll tick.
// Input channel (in_valid/in_ready): one transaction per poll tick, carrying
// the microsecond clock, the millisecond clock and the time of the latest
// sensor pulse. Output channel (out_valid/out_ready): exactly one result
// transaction per tick, in order, with timer state, live time, lap time and
// beam flags.
// A tick is first captured in the input register, then evaluated against the
// timer state and loaded into the result register, which raises out_valid.
// Throughput is one tick per cycle while the receiver keeps out_ready high;
// the state update and the result register load happen on the same edge, so
// no tick waits on the one before it.
// When the receiver stalls, the result register holds and the input register
// keeps one more tick; in_ready drops only once both are full.
// The configuration port writes a register on any edge with cfg_we high;
// indexes above five are ignored. Writes are expected only while idle.
// Synchronous reset loads the default configuration, puts the timer in
// ready with the beam restored, and empties both registers.
module light_beam_lap_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now_us,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_last_pulse_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_timer_state,
  output logic [31:0] out_live_time_us,
  output logic        out_lap_done,
  output logic [31:0] out_lap_time_us,
  output logic        out_beam_lost,
  output logic        out_in_progress,
  output logic        out_beam_broken,
  input  logic        cfg_we,
  input  logic [lblt_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Configuration registers.
  logic [31:0] break_window_r, cooldown_r, min_lap_r;
  logic [31:0] restore_debounce_r, min_restored_r, lost_timeout_r;

  // Input register.
  logic        s1_valid_r;
  logic [31:0] s1_now_us_r, s1_now_ms_r, s1_pulse_r;

  // Timer state.
  lblt_pkg::run_state_t run_state_r, run_state_nxt;
  logic [31:0] start_stamp_r, start_stamp_nxt;
  logic [31:0] end_stamp_r, end_stamp_nxt;
  logic [31:0] display_start_r, display_start_nxt;
  logic        broken_stable_r, broken_stable_nxt;
  logic        restored_stable_r, restored_stable_nxt;
  logic        restore_begin_v_r, restore_begin_v_nxt;
  logic [31:0] restore_begin_r, restore_begin_nxt;
  logic        lost_begin_v_r, lost_begin_v_nxt;
  logic [31:0] lost_begin_r, lost_begin_nxt;
  logic        restored_stamp_v_r, restored_stamp_v_nxt;
  logic [31:0] restored_stamp_r, restored_stamp_nxt;
  logic        measuring_r, measuring_nxt;
  logic [31:0] lap_r, lap_nxt;

  // Result computation.
  logic        broken, done, lost, can_stop;
  logic [31:0] live;
  logic        advance;

  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_window_r     <= lblt_pkg::BREAK_WINDOW_RST;
      cooldown_r         <= lblt_pkg::COOLDOWN_RST;
      min_lap_r          <= lblt_pkg::MIN_LAP_RST;
      restore_debounce_r <= lblt_pkg::RESTORE_DEBOUNCE_RST;
      min_restored_r     <= lblt_pkg::MIN_RESTORED_RST;
      lost_timeout_r     <= lblt_pkg::LOST_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lblt_pkg::REG_BREAK_WINDOW:     break_window_r     <= cfg_wdata;
        lblt_pkg::REG_COOLDOWN:         cooldown_r         <= cfg_wdata;
        lblt_pkg::REG_MIN_LAP:          min_lap_r          <= cfg_wdata;
        lblt_pkg::REG_RESTORE_DEBOUNCE: restore_debounce_r <= cfg_wdata;
        lblt_pkg::REG_MIN_RESTORED:     min_restored_r     <= cfg_wdata;
        lblt_pkg::REG_LOST_TIMEOUT:     lost_timeout_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_now_us_r <= in_now_us;
      s1_now_ms_r <= in_now_ms;
      s1_pulse_r  <= in_last_pulse_us;
    end
  end

  always_comb begin
    run_state_nxt        = run_state_r;
    start_stamp_nxt      = start_stamp_r;
    end_stamp_nxt        = end_stamp_r;
    display_start_nxt    = display_start_r;
    broken_stable_nxt    = broken_stable_r;
    restored_stable_nxt  = restored_stable_r;
    restore_begin_v_nxt  = restore_begin_v_r;
    restore_begin_nxt    = restore_begin_r;
    lost_begin_v_nxt     = lost_begin_v_r;
    lost_begin_nxt       = lost_begin_r;
    restored_stamp_v_nxt = restored_stamp_v_r;
    restored_stamp_nxt   = restored_stamp_r;
    measuring_nxt        = measuring_r;
    lap_nxt              = lap_r;
    done                 = 1'b0;

    broken   = (s1_now_us_r - s1_pulse_r) <= break_window_r;
    can_stop = restored_stamp_v_r && ((s1_now_us_r - restored_stamp_r) > min_restored_r);

    // Cooldown runs before the beam is looked at.
    if (run_state_r == lblt_pkg::ST_DISP && (s1_now_ms_r - display_start_r) > cooldown_r &&
        restored_stable_r) begin
      run_state_nxt = lblt_pkg::ST_READY;
      measuring_nxt = 1'b0;
    end

    if (broken) begin
      if (!lost_begin_v_r) begin
        lost_begin_v_nxt = 1'b1;
        lost_begin_nxt   = s1_now_us_r;
      end
      if (restored_stable_r) begin
        broken_stable_nxt   = 1'b1;
        restored_stable_nxt = 1'b0;
        restore_begin_v_nxt = 1'b0;
        case (run_state_nxt)
          lblt_pkg::ST_READY: begin
            start_stamp_nxt      = s1_now_us_r;
            measuring_nxt        = 1'b1;
            run_state_nxt        = lblt_pkg::ST_RUN;
            restored_stamp_v_nxt = 1'b0;
            display_start_nxt    = '0;
            lost_begin_v_nxt     = 1'b0;
          end
          lblt_pkg::ST_RUN: begin
            if (can_stop && (s1_now_us_r - start_stamp_r) > min_lap_r) begin
              end_stamp_nxt     = s1_now_us_r;
              lap_nxt           = s1_now_us_r - start_stamp_r;
              run_state_nxt     = lblt_pkg::ST_DISP;
              display_start_nxt = s1_now_ms_r;
              done              = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end else begin
      lost_begin_v_nxt = 1'b0;
      if (broken_stable_r && !restored_stable_r) begin
        // A fresh restore interval starts timing on this tick.
        if (!restore_begin_v_r) begin
          restore_begin_v_nxt = 1'b1;
          restore_begin_nxt   = s1_now_us_r;
        end
        if ((s1_now_us_r - restore_begin_nxt) > restore_debounce_r) begin
          restored_stable_nxt  = 1'b1;
          broken_stable_nxt    = 1'b0;
          restore_begin_v_nxt  = 1'b0;
          restored_stamp_v_nxt = 1'b1;
          restored_stamp_nxt   = s1_now_us_r;
        end
      end
    end

    case (run_state_nxt)
      lblt_pkg::ST_RUN:  live = s1_now_us_r - start_stamp_nxt;
      lblt_pkg::ST_DISP: live = end_stamp_nxt - start_stamp_nxt;
      default:           live = '0;
    endcase

    lost = broken_stable_nxt && !restored_stable_nxt && lost_begin_v_nxt &&
           ((s1_now_us_r - lost_begin_nxt) > lost_timeout_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_state_r        <= lblt_pkg::ST_READY;
      start_stamp_r      <= '0;
      end_stamp_r        <= '0;
      display_start_r    <= '0;
      broken_stable_r    <= 1'b0;
      restored_stable_r  <= 1'b1;
      restore_begin_v_r  <= 1'b0;
      restore_begin_r    <= '0;
      lost_begin_v_r     <= 1'b0;
      lost_begin_r       <= '0;
      restored_stamp_v_r <= 1'b0;
      restored_stamp_r   <= '0;
      measuring_r        <= 1'b0;
      lap_r              <= '0;
    end else if (advance) begin
      run_state_r        <= run_state_nxt;
      start_stamp_r      <= start_stamp_nxt;
      end_stamp_r        <= end_stamp_nxt;
      display_start_r    <= display_start_nxt;
      broken_stable_r    <= broken_stable_nxt;
      restored_stable_r  <= restored_stable_nxt;
      restore_begin_v_r  <= restore_begin_v_nxt;
      restore_begin_r    <= restore_begin_nxt;
      lost_begin_v_r     <= lost_begin_v_nxt;
      lost_begin_r       <= lost_begin_nxt;
      restored_stamp_v_r <= restored_stamp_v_nxt;
      restored_stamp_r   <= restored_stamp_nxt;
      measuring_r        <= measuring_nxt;
      lap_r              <= lap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_timer_state  <= run_state_nxt;
      out_live_time_us <= live;
      out_lap_done     <= done;
      out_lap_time_us  <= lap_nxt;
      out_beam_lost    <= lost;
      out_in_progress  <= measuring_nxt;
      out_beam_broken  <= broken;
    end
  end

endmodule

>>> sv/light_beam_lap_timer_checker.sv
module light_beam_lap_timer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_timer_state,
  input logic [31:0] out_live_time_us,
  input logic        out_lap_done,
  input logic [31:0] out_lap_time_us,
  input logic        out_in_progress
);

  // A stalled result transaction stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_live_time_us) &&
    $stable(out_timer_state) && $stable(out_lap_time_us))
    else $error("result changed while stalled");

  // A finished lap always leaves the timer displaying.
  a_done_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lap_done |-> out_timer_state == lblt_pkg::ST_DISP)
    else $error("lap_done without display state");

  // On the stopping tick the live time is the recorded lap.
  a_done_lap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lap_done |-> out_live_time_us == out_lap_time_us)
    else $error("live time differs from lap time on stop");

  // A measurement is in progress exactly when the timer is not ready.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_timer_state == lblt_pkg::ST_READY) == !out_in_progress)
    else $error("in_progress disagrees with timer state");

  // Ready shows no live time.
  a_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timer_state == lblt_pkg::ST_READY |-> out_live_time_us == '0)
    else $error("nonzero live time while ready");

endmodule

bind light_beam_lap_timer light_beam_lap_timer_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_timer_state  (out_timer_state),
  .out_live_time_us (out_live_time_us),
  .out_lap_done     (out_lap_done),
  .out_lap_time_us  (out_lap_time_us),
  .out_in_progress  (out_in_progress)
);

>>> verif/tb.sv
typedef struct packed {
  logic [1:0]  timer_state;
  logic [31:0] live_time_us;
  logic        lap_done;
  logic [31:0] lap_time_us;
  logic        beam_lost;
  logic        in_progress;
  logic        beam_broken;
} tick_result_t;

// Tracks the lap timer state tick by tick and holds the expected outcome of
// every accepted tick until the matching result transaction shows up.
class lap_tracker;
  logic [31:0] break_win, cooldown, min_lap, debounce, min_restored, lost_timeout;

  lblt_pkg::run_state_t phase;
  logic [31:0] start_us, end_us, disp_ms, lap_us;
  bit          broken_st, restored_st, measuring;
  bit          restore_v, lost_v, stamp_v;
  logic [31:0] restore_us, lost_us, stamp_us;

  tick_result_t pending_ticks[$];
  int           fail_count;

  function new();
    break_win    = lblt_pkg::BREAK_WINDOW_RST;
    cooldown     = lblt_pkg::COOLDOWN_RST;
    min_lap      = lblt_pkg::MIN_LAP_RST;
    debounce     = lblt_pkg::RESTORE_DEBOUNCE_RST;
    min_restored = lblt_pkg::MIN_RESTORED_RST;
    lost_timeout = lblt_pkg::LOST_TIMEOUT_RST;
    phase        = lblt_pkg::ST_READY;
    start_us     = '0;
    end_us       = '0;
    disp_ms      = '0;
    lap_us       = '0;
    broken_st    = 1'b0;
    restored_st  = 1'b1;
    measuring    = 1'b0;
    restore_v    = 1'b0;
    lost_v       = 1'b0;
    stamp_v      = 1'b0;
    restore_us   = '0;
    lost_us      = '0;
    stamp_us     = '0;
    fail_count   = 0;
  endfunction

  function void write_reg(logic [lblt_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    case (idx)
      lblt_pkg::REG_BREAK_WINDOW:     break_win = val;
      lblt_pkg::REG_COOLDOWN:         cooldown = val;
      lblt_pkg::REG_MIN_LAP:          min_lap = val;
      lblt_pkg::REG_RESTORE_DEBOUNCE: debounce = val;
      lblt_pkg::REG_MIN_RESTORED:     min_restored = val;
      lblt_pkg::REG_LOST_TIMEOUT:     lost_timeout = val;
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_ticks.size();
  endfunction

  function void note_tick(logic [31:0] now_us, logic [31:0] now_ms, logic [31:0] pulse);
    tick_result_t r;
    logic [31:0]  age;
    bit           hit, done, can_stop;
    age  = now_us - pulse;
    hit  = age <= break_win;
    done = 1'b0;

    // The display only times out once the beam has settled back to restored.
    if (phase == lblt_pkg::ST_DISP && (now_ms - disp_ms) > cooldown && restored_st) begin
      phase     = lblt_pkg::ST_READY;
      measuring = 1'b0;
    end

    if (hit) begin
      if (!lost_v) begin
        lost_v  = 1'b1;
        lost_us = now_us;
      end
      if (restored_st) begin
        can_stop    = stamp_v && (now_us - stamp_us) > min_restored;
        broken_st   = 1'b1;
        restored_st = 1'b0;
        restore_v   = 1'b0;
        if (phase == lblt_pkg::ST_READY) begin
          start_us  = now_us;
          measuring = 1'b1;
          phase     = lblt_pkg::ST_RUN;
          stamp_v   = 1'b0;
          disp_ms   = '0;
          lost_v    = 1'b0;
        end else if (phase == lblt_pkg::ST_RUN && can_stop &&
                     (now_us - start_us) > min_lap) begin
          end_us  = now_us;
          lap_us  = now_us - start_us;
          phase   = lblt_pkg::ST_DISP;
          disp_ms = now_ms;
          done    = 1'b1;
        end
      end
    end else begin
      lost_v = 1'b0;
      if (broken_st && !restored_st) begin
        if (!restore_v) begin
          restore_v  = 1'b1;
          restore_us = now_us;
        end
        if ((now_us - restore_us) > debounce) begin
          restored_st = 1'b1;
          broken_st   = 1'b0;
          restore_v   = 1'b0;
          stamp_v     = 1'b1;
          stamp_us    = now_us;
        end
      end
    end

    r.timer_state = phase;
    if (phase == lblt_pkg::ST_RUN) r.live_time_us = now_us - start_us;
    else if (phase == lblt_pkg::ST_DISP) r.live_time_us = end_us - start_us;
    else r.live_time_us = '0;
    r.lap_done    = done;
    r.lap_time_us = lap_us;
    r.beam_lost   = broken_st && !restored_st && lost_v && (now_us - lost_us) > lost_timeout;
    r.in_progress = measuring;
    r.beam_broken = hit;
    pending_ticks.push_back(r);
  endfunction

  function void check_tick(tick_result_t got);
    tick_result_t exp_r;
    if (pending_ticks.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result transaction with no tick pending");
      return;
    end
    exp_r = pending_ticks.pop_front();
    if (got.timer_state !== exp_r.timer_state || got.live_time_us !== exp_r.live_time_us ||
        got.lap_done !== exp_r.lap_done || got.lap_time_us !== exp_r.lap_time_us ||
        got.beam_lost !== exp_r.beam_lost || got.in_progress !== exp_r.in_progress ||
        got.beam_broken !== exp_r.beam_broken) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch: expected state=%0d live=%0d done=%0b lap=%0d lost=%0b prog=%0b brk=%0b",
                 exp_r.timer_state, exp_r.live_time_us, exp_r.lap_done, exp_r.lap_time_us,
                 exp_r.beam_lost, exp_r.in_progress, exp_r.beam_broken);
        $display("          actual   state=%0d live=%0d done=%0b lap=%0d lost=%0b prog=%0b brk=%0b",
                 got.timer_state, got.live_time_us, got.lap_done, got.lap_time_us,
                 got.beam_lost, got.in_progress, got.beam_broken);
      end
    end
  endfunction
endclass

module tb;
  localparam logic [lblt_pkg::CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [lblt_pkg::CfgIdxW-1:0] REG_SPARE_B = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 64;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [31:0]         in_now_us = '0;
  logic [31:0]         in_now_ms = '0;
  logic [31:0]         in_last_pulse_us = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_timer_state;
  logic [31:0]         out_live_time_us;
  logic                out_lap_done;
  logic [31:0]         out_lap_time_us;
  logic                out_beam_lost;
  logic                out_in_progress;
  logic                out_beam_broken;
  logic                cfg_we = 1'b0;
  logic [lblt_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]         cfg_wdata = '0;

  lap_tracker   tracker;
  tick_result_t seen;
  int           idle_cycles = 0;
  int           burst_left = 0;
  bit           hold_req = 1'b0;
  bit           beam_intact = 1'b1;
  logic [31:0]  clk_us = '0;
  logic [31:0]  clk_ms = '0;

  light_beam_lap_timer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_now_us        (in_now_us),
    .in_now_ms        (in_now_ms),
    .in_last_pulse_us (in_last_pulse_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_timer_state  (out_timer_state),
    .out_live_time_us (out_live_time_us),
    .out_lap_done     (out_lap_done),
    .out_lap_time_us  (out_lap_time_us),
    .out_beam_lost    (out_beam_lost),
    .out_in_progress  (out_in_progress),
    .out_beam_broken  (out_beam_broken),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        tracker.note_tick(in_now_us, in_now_ms, in_last_pulse_us);
      if (out_valid && out_ready) begin
        seen = '{timer_state: out_timer_state, live_time_us: out_live_time_us,
                 lap_done: out_lap_done, lap_time_us: out_lap_time_us,
                 beam_lost: out_beam_lost, in_progress: out_in_progress,
                 beam_broken: out_beam_broken};
        tracker.check_tick(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("light_beam_lap_timer test failed");
        $finish;
      end
    end
  end

  // The result side stalls in segments, each with its own pattern. A pending
  // hold request turns the next segment into one long stall.
  initial begin : receiver
    int seg_len, mode, k;
    forever begin
      seg_len = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        for (k = 0; k < seg_len; k++) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 0);
            2: out_ready <= ($urandom_range(0, 9) != 0);
            default: out_ready <= (k % 5 != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_tick(input logic [31:0] us, input logic [31:0] ms, input logic [31:0] pulse);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_now_us        <= us;
    in_now_ms        <= ms;
    in_last_pulse_us <= pulse;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_aged(input logic [31:0] us, input logic [31:0] ms, input logic [31:0] age);
    send_tick(us, ms, us - age);
  endtask

  task automatic write_reg(input logic [lblt_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic apply_config(input logic [31:0] bw, input logic [31:0] cd, input logic [31:0] ml,
                              input logic [31:0] rd, input logic [31:0] mr, input logic [31:0] lt);
    write_reg(lblt_pkg::REG_BREAK_WINDOW, bw);
    write_reg(lblt_pkg::REG_COOLDOWN, cd);
    write_reg(lblt_pkg::REG_MIN_LAP, ml);
    write_reg(lblt_pkg::REG_RESTORE_DEBOUNCE, rd);
    write_reg(lblt_pkg::REG_MIN_RESTORED, mr);
    write_reg(lblt_pkg::REG_LOST_TIMEOUT, lt);
    // Writes beyond the last register must leave the configuration alone.
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Walks the default configuration through start, lost beam, consumed
  // breaks, a real stop, a break during display and the cooldown, with the
  // clocks wrapping and the comparisons sitting on their boundaries.
  task automatic run_directed();
    logic [31:0] b;
    b = 32'hFFFF_FFFF;
    send_tick(32'h0, 32'h0, 32'h8000_0000);
    send_aged(b, b, 32'd0);
    send_aged(b + 32'd5000000, 32'd5000, 32'd4000);
    send_aged(b + 32'd16000000, 32'd16000, 32'd0);
    send_aged(b + 32'd16100000, 32'd16100, 32'd4001);
    send_aged(b + 32'd16300000, 32'd16300, 32'd90000);
    send_aged(b + 32'd16300001, 32'd16300, 32'd90001);
    send_aged(b + 32'd16500000, 32'd16500, 32'd10);
    send_aged(b + 32'd16600000, 32'd16600, 32'hFFFF_FFFF);
    send_aged(b + 32'd16900000, 32'd16900, 32'd50000);
    send_aged(b + 32'd18900000, 32'd18900, 32'd1);
    send_aged(b + 32'd19000000, 32'd19000, 32'd5000);
    send_aged(b + 32'd19300000, 32'd19300, 32'd5000);
    send_aged(b + 32'd21400000, 32'd21400, 32'd100);
    send_aged(b + 32'd21500000, 32'd21500, 32'd8000);
    send_aged(b + 32'd21800000, 32'd21800, 32'd8000);
    send_aged(b + 32'd22000000, 32'd22000, 32'd0);
    send_aged(b + 32'd22100000, 32'd24400, 32'd7000);
    send_aged(b + 32'd22400000, 32'd24401, 32'd7000);
    send_aged(b + 32'd22500000, 32'd24402, 32'd7000);
    send_aged(b + 32'd23000000, 32'd24900, 32'd0);
    send_aged(b + 32'd23100000, 32'd25000, 32'd3999);
    send_tick(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
  endtask

  // Mostly a plausible poll stream: clocks move forward, the beam is held
  // broken or intact for a while. A few ticks are pure noise or jumps.
  task automatic run_random(input int n, input int unsigned step_max,
                            input int unsigned ms_max, input int unsigned flip);
    int          k, r;
    logic [31:0] age;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_tick($urandom, $urandom, $urandom);
      end else begin
        if (r < 12) clk_us = clk_us + $urandom;
        if ($urandom_range(0, 9) == 0) clk_us = clk_us + $urandom_range(0, step_max * 8);
        else clk_us = clk_us + $urandom_range(0, step_max);
        clk_ms = clk_ms + $urandom_range(0, ms_max);
        if ($urandom_range(1, flip) == 1) beam_intact = !beam_intact;
        if (!beam_intact) begin
          case ($urandom_range(0, 3))
            0: age = '0;
            1: age = tracker.break_win;
            default: age = $urandom_range(0, tracker.break_win);
          endcase
        end else if (tracker.break_win >= 32'hFFFF_0000) begin
          age = 32'hFFFF_FFFF;
        end else begin
          age = tracker.break_win + 32'd1 + $urandom_range(0, step_max);
        end
        send_aged(clk_us, clk_ms, age);
      end
    end
  endtask

  initial begin : stimulus
    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_drained();

    apply_config(32'd100, 32'd5, 32'd1000, 32'd200, 32'd300, 32'd600);
    clk_us = 32'hFFFF_F000;
    clk_ms = 32'hFFFF_FFF0;
    hold_req = 1'b1;
    run_random(250, 300, 2, 5);
    wait_drained();

    apply_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_random(100, 50, 1, 3);
    wait_drained();

    apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(80, 1000, 5, 4);
    wait_drained();

    apply_config(lblt_pkg::BREAK_WINDOW_RST, lblt_pkg::COOLDOWN_RST, lblt_pkg::MIN_LAP_RST,
                 lblt_pkg::RESTORE_DEBOUNCE_RST, lblt_pkg::MIN_RESTORED_RST,
                 lblt_pkg::LOST_TIMEOUT_RST);
    run_random(250, 800000, 800, 8);
    wait_drained();

    apply_config($urandom_range(0, 400), $urandom_range(0, 8), $urandom_range(0, 2000),
                 $urandom_range(0, 600), $urandom_range(0, 1500), $urandom_range(0, 3000));
    run_random(110, 500, 3, 5);
    wait_drained();

    apply_config($urandom_range(0, 400), $urandom_range(0, 8), $urandom_range(0, 2000),
                 $urandom_range(0, 600), $urandom_range(0, 1500), $urandom_range(0, 3000));
    run_random(110, 500, 3, 5);
    wait_drained();

    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("light_beam_lap_timer test passed");
    end else begin
      $display("light_beam_lap_timer test failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/lblt_pkg.sv
sv/light_beam_lap_timer.sv
sv/light_beam_lap_timer_checker.sv
verif/tb.sv
